// ===== rtl/core/vsc_pkg.sv =====
// Shared types and constants of the vertical seam cost unit.
// Standalone; imported by the channel interfaces and the top level.
package vsc_pkg;

  // Field widths fixed by the pixel and result formats
  localparam int COLOR_BITS      = 8;
  localparam int ROW_WIDTH_BITS  = 13;
  localparam int PROT_BITS       = 24;
  localparam int OUT_COST_BITS   = 24;
  localparam int OUT_COL_BITS    = 12;
  localparam int CFG_DATA_BITS   = 24;
  localparam int CFG_IDX_BITS    = 2;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_COST_BITS   = 24;

  // Register reset values
  localparam int ROW_WIDTH_RESET = 4096;
  localparam int PROTECT_RESET   = 10000;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW_WIDTH    = 2'd0,
    CFG_PROTECT_COST = 2'd1
  } cfg_idx_t;

  // Predecessor column codes
  typedef enum logic [1:0] {
    STEP_LEFT  = 2'd0,
    STEP_UP    = 2'd1,
    STEP_RIGHT = 2'd2
  } step_t;

  typedef struct packed {
    logic                  start_frame;
    logic [COLOR_BITS-1:0] pix_red;
    logic [COLOR_BITS-1:0] pix_green;
    logic [COLOR_BITS-1:0] pix_blue;
    logic [COLOR_BITS-1:0] next_red;
    logic [COLOR_BITS-1:0] next_green;
    logic [COLOR_BITS-1:0] next_blue;
    logic                  protected_pixel;
  } pix_item_t;

  typedef struct packed {
    logic [OUT_COST_BITS-1:0] cum_cost;
    logic [1:0]               back_step;
    logic                     row_end;
    logic [OUT_COL_BITS-1:0]  best_column;
    logic [OUT_COST_BITS-1:0] best_cost;
  } cost_item_t;

endpackage

// ===== rtl/core/vsc_if.sv =====
// Valid/ready channel interfaces for pixels in and seam costs out.
// Depends on vsc_pkg for the payload structs.
interface vsc_pix_if;
  import vsc_pkg::*;
  logic      valid;
  logic      ready;
  pix_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vsc_cost_if;
  import vsc_pkg::*;
  logic       valid;
  logic       ready;
  cost_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/vertical_seam_cost_dp_unit.sv =====
// Top level of the vertical seam cumulative cost unit.
// Depends on vsc_pkg and on the channel interfaces in vsc_if.sv.

// Streams RGB pixels in raster order and returns one cost result per pixel:
// the cumulative seam cost, the predecessor column (ties go left, then
// straight), a row-end flag and the running least cost of the row with its
// column. Throughput is one pixel per clock while the output is not
// stalled; each result is held in the input register and then in the result
// register before it can transfer out. The
// figure is set by the line store, which takes one cost write and two
// registered reads (up and up-right) per cycle; a result written in the
// same cycle as a read of its entry is forwarded around the store. The line
// store holds MAX_WIDTH costs of COST_BITS bits and is not cleared: after
// reset it needs no clearing pass, but the first row of a frame must be at
// least as wide as any later row so that every entry read was written.
// row_width is clamped to 2..MAX_WIDTH; protect_cost saturates to the cost
// maximum. Write configuration only while no pixel is in flight.
module vertical_seam_cost_dp_unit #(
  parameter int MAX_WIDTH = vsc_pkg::DEF_MAX_WIDTH,
  parameter int COST_BITS = vsc_pkg::DEF_COST_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vsc_pix_if.sink                           in_px,
  vsc_cost_if.source                        out_cost,
  input  logic                              cfg_we,
  input  vsc_pkg::cfg_idx_t                 cfg_idx,
  input  logic [vsc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import vsc_pkg::*;

  localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_BITS) ?
                      $clog2(MAX_WIDTH + 1) : ROW_WIDTH_BITS;
  localparam int PW = (COST_BITS > PROT_BITS) ? COST_BITS : PROT_BITS;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;
  // x/3 for x < 768 as (x * 683) >> 11
  localparam int SUM_BITS   = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_BITS  = 2 * SUM_BITS;

  // Configuration registers
  logic [ROW_WIDTH_BITS-1:0] row_width_r;
  logic [PROT_BITS-1:0]      protect_r;

  // Column tracking at the input side
  logic [AW-1:0] col_cnt_r;
  logic          first_row_r;

  // Stage 1: input register and line store read data
  logic                 s1_valid_r;
  pix_item_t            s1_item_r;
  logic [AW-1:0]        s1_col_r;
  logic                 s1_last_r;
  logic                 s1_first_r;
  logic [COST_BITS-1:0] rd_a_r, rd_b_r;
  logic                 fwd_a_r, fwd_b_r;
  logic [COST_BITS-1:0] fwd_data_r;

  // Row state updated as a pixel leaves stage 1
  logic [COST_BITS-1:0] held_left_r;
  logic [COST_BITS-1:0] run_min_cost_r;
  logic [AW-1:0]        run_min_col_r;

  // Result register
  logic       out_valid_r;
  cost_item_t out_data_r;

  // Line store
  logic [COST_BITS-1:0] line_mem [MAX_WIDTH];

  // Handshake
  logic in_fire, s1_adv, out_free;

  assign out_free    = !out_valid_r || out_cost.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_px.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_px.valid && in_px.ready;

  assign out_cost.valid = out_valid_r;
  assign out_cost.data  = out_data_r;

  // Clamp row width and find the last column index
  logic [WW-1:0] width_ext, width_cl;
  logic [AW-1:0] last_idx;

  always_comb begin
    width_ext = WW'(row_width_r);
    width_cl  = width_ext;
    if (width_ext < WW'(2)) begin
      width_cl = WW'(2);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_cl = WW'(MAX_WIDTH);
    end
    last_idx = AW'(width_cl - WW'(1));
  end

  // Input side: column of the arriving pixel and line store addresses
  logic [AW-1:0] in_cnt, in_col, rd_addr_a, rd_addr_b;
  logic          in_first, in_last;

  always_comb begin
    in_cnt   = in_px.data.start_frame ? '0 : col_cnt_r;
    in_first = in_px.data.start_frame ? 1'b1 : first_row_r;
    in_last  = (in_cnt >= last_idx);
    in_col   = in_last ? last_idx : in_cnt;
    rd_addr_a = in_col;
    rd_addr_b = in_last ? in_col : in_col + AW'(1);
  end

  // Stage 1 datapath: energy, predecessor choice, saturating add
  logic [SUM_BITS-1:0]    sum_p, sum_n, diff;
  logic [PROD_BITS-1:0]   prod;
  logic [COST_BITS-1:0]   energy, up_val, ur_val, best, cost_nxt, prot_sat;
  logic [COST_BITS-1:0]   min_cost_nxt;
  logic [AW-1:0]          min_col_nxt;
  logic [COST_BITS:0]     sum_c;
  step_t                  step_nxt;
  logic                   take_min;

  always_comb begin
    sum_p = SUM_BITS'(s1_item_r.pix_red) + SUM_BITS'(s1_item_r.pix_green) +
            SUM_BITS'(s1_item_r.pix_blue);
    sum_n = SUM_BITS'(s1_item_r.next_red) + SUM_BITS'(s1_item_r.next_green) +
            SUM_BITS'(s1_item_r.next_blue);
    if (s1_last_r) begin
      diff = sum_p;
    end else if (sum_p >= sum_n) begin
      diff = sum_p - sum_n;
    end else begin
      diff = sum_n - sum_p;
    end
    prod   = PROD_BITS'(diff) * PROD_BITS'(DIV3_MUL);
    energy = COST_BITS'(prod[PROD_BITS-1:DIV3_SHIFT]);

    up_val = fwd_a_r ? fwd_data_r : rd_a_r;
    ur_val = fwd_b_r ? fwd_data_r : rd_b_r;

    best     = '0;
    step_nxt = STEP_UP;
    if (!s1_first_r) begin
      if (s1_col_r == '0) begin
        if (up_val <= ur_val) begin
          best     = up_val;
          step_nxt = STEP_UP;
        end else begin
          best     = ur_val;
          step_nxt = STEP_RIGHT;
        end
      end else if (s1_last_r) begin
        if (held_left_r <= up_val) begin
          best     = held_left_r;
          step_nxt = STEP_LEFT;
        end else begin
          best     = up_val;
          step_nxt = STEP_UP;
        end
      end else begin
        best     = held_left_r;
        step_nxt = STEP_LEFT;
        if (up_val < best) begin
          best     = up_val;
          step_nxt = STEP_UP;
        end
        if (ur_val < best) begin
          best     = ur_val;
          step_nxt = STEP_RIGHT;
        end
      end
    end

    sum_c = {1'b0, best} + {1'b0, energy};
    if (s1_first_r) begin
      cost_nxt = energy;
    end else if (sum_c[COST_BITS]) begin
      cost_nxt = COST_MAX;
    end else begin
      cost_nxt = sum_c[COST_BITS-1:0];
    end

    // Protected pixels take the protect cost, clipped to the cost range
    prot_sat = (PW'(protect_r) > PW'(COST_MAX)) ? COST_MAX : COST_BITS'(protect_r);
    if (s1_item_r.protected_pixel) begin
      cost_nxt = prot_sat;
    end

    // Running row minimum; earliest column wins a tie
    take_min     = (s1_col_r == '0) || (cost_nxt < run_min_cost_r);
    min_cost_nxt = take_min ? cost_nxt : run_min_cost_r;
    min_col_nxt  = take_min ? s1_col_r : run_min_col_r;
  end

  // Line store: write the finished cost, read up and up-right for the next pixel
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col_r] <= cost_nxt;
    end
    if (in_fire) begin
      rd_a_r <= line_mem[rd_addr_a];
      rd_b_r <= line_mem[rd_addr_b];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_BITS'(ROW_WIDTH_RESET);
      protect_r      <= PROT_BITS'(PROTECT_RESET);
      col_cnt_r      <= '0;
      first_row_r    <= 1'b1;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      held_left_r    <= '0;
      run_min_cost_r <= COST_MAX;
      run_min_col_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ROW_WIDTH:    row_width_r <= cfg_wdata[ROW_WIDTH_BITS-1:0];
          CFG_PROTECT_COST: protect_r   <= cfg_wdata[PROT_BITS-1:0];
          default: ;
        endcase
      end

      // Advance the column; the last column closes the row
      if (in_fire) begin
        if (in_last) begin
          col_cnt_r   <= '0;
          first_row_r <= 1'b0;
        end else begin
          col_cnt_r   <= in_col + AW'(1);
          first_row_r <= in_first;
        end
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_cost.ready) begin
        out_valid_r <= 1'b0;
      end

      // Save the up cost as the next pixel's up-left before it is overwritten
      if (s1_adv) begin
        held_left_r <= up_val;
        if (s1_last_r) begin
          run_min_cost_r <= COST_MAX;
          run_min_col_r  <= '0;
        end else begin
          run_min_cost_r <= min_cost_nxt;
          run_min_col_r  <= min_col_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r  <= in_px.data;
      s1_col_r   <= in_col;
      s1_last_r  <= in_last;
      s1_first_r <= in_first;
      // Forward a cost written at this very edge to the entry being read
      fwd_a_r    <= s1_adv && (s1_col_r == rd_addr_a);
      fwd_b_r    <= s1_adv && (s1_col_r == rd_addr_b);
      fwd_data_r <= cost_nxt;
    end
    if (s1_adv) begin
      out_data_r.cum_cost    <= OUT_COST_BITS'(cost_nxt);
      out_data_r.back_step   <= step_nxt;
      out_data_r.row_end     <= s1_last_r;
      out_data_r.best_column <= OUT_COL_BITS'(min_col_nxt);
      out_data_r.best_cost   <= OUT_COST_BITS'(min_cost_nxt);
    end
  end

endmodule
